[hw/rtl/esp_pkg.sv]
// shared types, constants and name tables for the event stream line parser
package esp_pkg;

	// token queue sizing (depth must be a power of two)
	localparam int TOK_FIFO_DEPTH = 4;
	localparam int TOK_PTR_W      = $clog2(TOK_FIFO_DEPTH);
	localparam int TOK_LVL_W      = $clog2(TOK_FIFO_DEPTH + 1);

	// input item kinds
	localparam logic ITEM_BYTE = 1'b0;
	localparam logic ITEM_EOS  = 1'b1;

	// stream characters
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// output token kinds
	typedef enum logic [2:0] {
		TK_TYPE_BEGIN = 3'd0,
		TK_TYPE_BYTE  = 3'd1,
		TK_DATA_BYTE  = 3'd2,
		TK_DATA_BREAK = 3'd3,
		TK_DISPATCH   = 3'd4
	} tok_kind_t;

	// line phase, one-hot
	typedef enum logic [6:0] {
		PH_START    = 7'b0000001,
		PH_NAME     = 7'b0000010,
		PH_SKIP     = 7'b0000100,
		PH_EV_FIRST = 7'b0001000,
		PH_EV       = 7'b0010000,
		PH_DA_FIRST = 7'b0100000,
		PH_DA       = 7'b1000000
	} phase_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  data;
		logic        last;
	} tok_t;

	// token queue status toward the front end
	typedef struct packed {
		logic [TOK_LVL_W-1:0] level;
		logic                 room;
	} fifo_stat_t;

	// characters of the field name "event"
	function automatic logic [7:0] event_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h65;
			3'd1: c = 8'h76;
			3'd2: c = 8'h65;
			3'd3: c = 8'h6e;
			3'd4: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// characters of the field name "data"
	function automatic logic [7:0] data_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h64;
			3'd1: c = 8'h61;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/esp_if.sv]
// valid/ready channel interfaces for stream items and tokens
interface esp_item_if;
	logic       valid;
	logic       ready;
	logic       item_kind;
	logic [7:0] byte_value;

	modport source(output valid, item_kind, byte_value, input ready);
	modport sink(input valid, item_kind, byte_value, output ready);
endinterface

interface esp_token_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [7:0] token_byte;
	logic       last_of_item;

	modport source(output valid, token_kind, token_byte, last_of_item, input ready);
	modport sink(input valid, token_kind, token_byte, last_of_item, output ready);
endinterface

[hw/rtl/esp_parser.sv]
// line state and token generation for one stream item per cycle while adv is high
module esp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          item_kind,
	input  logic [7:0]    byte_value,
	output logic [1:0]    push_n,
	output esp_pkg::tok_t tok0,
	output esp_pkg::tok_t tok1
);
	import esp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] pos_q, pos_d;
	logic [1:0] cand_q, cand_d;
	logic       cr_q, cr_d;
	logic       pend_q, pend_d;
	logic       dseen_q, dseen_d;

	logic       nd_ev, nd_da;
	logic       ev_hit, da_hit;
	logic       emit_a, emit_disp;
	tok_kind_t  kind_a;
	logic [7:0] data_a;

	// name match against the current position
	assign nd_ev  = cand_q[0] && (pos_q == 3'd5);
	assign nd_da  = cand_q[1] && (pos_q == 3'd4);
	assign ev_hit = (pos_q < 3'd5) && (byte_value == event_char(pos_q));
	assign da_hit = (pos_q < 3'd4) && (byte_value == data_char(pos_q));

	// next state and up to two tokens
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		cand_d    = cand_q;
		cr_d      = cr_q;
		pend_d    = pend_q;
		dseen_d   = dseen_q;
		emit_a    = 1'b0;
		kind_a    = TK_TYPE_BEGIN;
		data_a    = 8'h00;
		emit_disp = 1'b0;

		if (item_kind == ITEM_EOS) begin
			// flush an open name, then dispatch
			if (phase_q == PH_NAME) begin
				if (nd_ev) begin
					emit_a = 1'b1;
					kind_a = TK_TYPE_BEGIN;
				end else if (nd_da) begin
					emit_a = dseen_q;
					kind_a = TK_DATA_BREAK;
				end
			end
			emit_disp = pend_q || ((phase_q == PH_NAME) && (nd_ev || nd_da));
			pend_d    = 1'b0;
			dseen_d   = 1'b0;
			phase_d   = PH_START;
			pos_d     = 3'd0;
			cand_d    = 2'b00;
			cr_d      = 1'b0;
		end else if (cr_q && (byte_value == CH_LF)) begin
			// lf of a crlf pair
			cr_d = 1'b0;
		end else if (byte_value inside {CH_LF, CH_CR}) begin
			// line end
			cr_d = (byte_value == CH_CR);
			if (phase_q == PH_START) begin
				emit_disp = pend_q;
				pend_d    = 1'b0;
				dseen_d   = 1'b0;
			end else if (phase_q == PH_NAME) begin
				if (nd_ev) begin
					emit_a = 1'b1;
					kind_a = TK_TYPE_BEGIN;
					pend_d = 1'b1;
				end else if (nd_da) begin
					emit_a  = dseen_q;
					kind_a  = TK_DATA_BREAK;
					dseen_d = 1'b1;
					pend_d  = 1'b1;
				end
			end
			phase_d = PH_START;
			pos_d   = 3'd0;
			cand_d  = 2'b00;
		end else begin
			cr_d = 1'b0;
			case (phase_q)
				PH_START: begin
					if (byte_value == CH_COLON) begin
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_NAME;
						pos_d   = 3'd1;
						cand_d  = {byte_value == data_char(3'd0),
							byte_value == event_char(3'd0)};
					end
				end
				PH_NAME: begin
					if (byte_value == CH_COLON) begin
						if (nd_ev) begin
							emit_a  = 1'b1;
							kind_a  = TK_TYPE_BEGIN;
							pend_d  = 1'b1;
							phase_d = PH_EV_FIRST;
						end else if (nd_da) begin
							emit_a  = dseen_q;
							kind_a  = TK_DATA_BREAK;
							dseen_d = 1'b1;
							pend_d  = 1'b1;
							phase_d = PH_DA_FIRST;
						end else begin
							phase_d = PH_SKIP;
						end
					end else begin
						cand_d = cand_q & {da_hit, ev_hit};
						pos_d  = (pos_q == 3'd7) ? pos_q : pos_q + 3'd1;
					end
				end
				PH_EV_FIRST: begin
					phase_d = PH_EV;
					emit_a  = (byte_value != CH_SPACE);
					kind_a  = TK_TYPE_BYTE;
					data_a  = byte_value;
				end
				PH_EV: begin
					emit_a = 1'b1;
					kind_a = TK_TYPE_BYTE;
					data_a = byte_value;
				end
				PH_DA_FIRST: begin
					phase_d = PH_DA;
					emit_a  = (byte_value != CH_SPACE);
					kind_a  = TK_DATA_BYTE;
					data_a  = byte_value;
				end
				PH_DA: begin
					emit_a = 1'b1;
					kind_a = TK_DATA_BYTE;
					data_a = byte_value;
				end
				default: begin
				end
			endcase
		end
	end

	// pack tokens into slots, last flag on the final one
	always_comb begin
		tok0   = '{kind: TK_TYPE_BEGIN, data: 8'h00, last: 1'b0};
		tok1   = '{kind: TK_TYPE_BEGIN, data: 8'h00, last: 1'b0};
		push_n = 2'd0;
		if (emit_a) begin
			tok0 = '{kind: kind_a, data: data_a, last: !emit_disp};
			if (emit_disp) begin
				tok1   = '{kind: TK_DISPATCH, data: 8'h00, last: 1'b1};
				push_n = 2'd2;
			end else begin
				push_n = 2'd1;
			end
		end else if (emit_disp) begin
			tok0   = '{kind: TK_DISPATCH, data: 8'h00, last: 1'b1};
			push_n = 2'd1;
		end
		if (!adv) begin
			push_n = 2'd0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pos_q   <= 3'd0;
			cand_q  <= 2'b00;
			cr_q    <= 1'b0;
			pend_q  <= 1'b0;
			dseen_q <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			cand_q  <= cand_d;
			cr_q    <= cr_d;
			pend_q  <= pend_d;
			dseen_q <= dseen_d;
		end
	end

endmodule

[hw/rtl/esp_tok_fifo.sv]
// small token queue taking up to two tokens per cycle and giving one while the sink is ready
module esp_tok_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  esp_pkg::tok_t       tok0,
	input  esp_pkg::tok_t       tok1,
	esp_token_if.source         token,
	output esp_pkg::fifo_stat_t stat
);
	import esp_pkg::*;

	localparam logic [TOK_LVL_W-1:0] ROOM_MAX = TOK_LVL_W'(TOK_FIFO_DEPTH - 2);

	tok_t                 mem_q [TOK_FIFO_DEPTH];
	logic [TOK_PTR_W-1:0] wr_ptr_q;
	logic [TOK_PTR_W-1:0] rd_ptr_q;
	logic [TOK_LVL_W-1:0] level_q;
	logic                 pop;
	tok_t                 head;

	// head of queue to the output channel
	assign pop                = token.valid && token.ready;
	assign head               = mem_q[rd_ptr_q];
	assign token.valid        = (level_q != '0);
	assign token.token_kind   = head.kind;
	assign token.token_byte   = head.data;
	assign token.last_of_item = head.last;

	assign stat.level = level_q;
	assign stat.room  = (level_q <= ROOM_MAX);

	// storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= tok0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + TOK_PTR_W'(1)] <= tok1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + TOK_PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + TOK_PTR_W'(pop);
			level_q  <= level_q + TOK_LVL_W'(push_n) - TOK_LVL_W'(pop);
		end
	end

endmodule

[hw/rtl/event_stream_line_parser_core.sv]
// top level of the event stream line parser
// Takes one stream byte or end-of-stream request per cycle and turns it into
// tokens: type begin, type bytes, data bytes, data line breaks and dispatch.
// A request is registered, parsed against the line state while it is held in
// that register, and its tokens (one at most for a byte, two at most for end
// of stream) enter a four-entry token queue, whose head drives the token
// output. Sustained rate is one request per cycle; the input stalls only
// while the token queue holds more than two tokens, which happens when the
// token sink holds off or end-of-stream requests come faster than their two
// tokens drain.
module event_stream_line_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	esp_item_if.sink    item,
	esp_token_if.source token
);
	import esp_pkg::*;

	logic       item_valid_s1;
	logic       item_kind_s1;
	logic [7:0] byte_value_s1;
	logic       adv;
	logic [1:0] push_n;
	tok_t       tok0, tok1;
	fifo_stat_t stat;

	// input register
	assign adv        = item_valid_s1 && stat.room;
	assign item.ready = !item_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_kind_s1  <= item.item_kind;
			byte_value_s1 <= item.byte_value;
		end
	end

	// line parser
	esp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item_kind (item_kind_s1),
		.byte_value(byte_value_s1),
		.push_n    (push_n),
		.tok0      (tok0),
		.tok1      (tok1)
	);

	// token queue
	esp_tok_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.tok0  (tok0),
		.tok1  (tok1),
		.token (token),
		.stat  (stat)
	);

	// a stream byte never yields more than one token
	a_byte_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (item_kind_s1 == ITEM_BYTE)) |-> (push_n != 2'd2))
		else $error("byte request produced two tokens");

	// the last pushed token of a request carries the last flag, and only it
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |->
		((push_n == 2'd1 && tok0.last) || (push_n == 2'd2 && !tok0.last && tok1.last)))
		else $error("last flag misplaced on pushed tokens");

	// the token queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.level <= TOK_LVL_W'(TOK_FIFO_DEPTH))
		else $error("token queue overflow");

endmodule

[tb/sv/event_stream_line_parser_core_tb.sv]
// self-checking testbench for the event stream line parser core
module event_stream_line_parser_core_tb;
	import esp_pkg::*;

	localparam int RANDOM_REQUESTS = 1850;
	localparam int WATCHDOG_LIMIT  = 500;
	localparam int DRAIN_CYCLES    = 8;
	localparam int SIDE_ITEM       = 0;
	localparam int SIDE_TOKEN      = 1;

	typedef struct {
		logic       kind;
		logic [7:0] value;
	} stream_req_t;

	// token predictor and expected token store
	class token_scoreboard;
		phase_t     phase;
		logic [2:0] name_pos;
		bit         type_possible;
		bit         data_possible;
		bit         after_cr;
		bit         pending;
		bit         data_seen;
		string      type_name = "event";
		string      data_name = "data";
		tok_t       expected_q[$];
		tok_t       item_toks[$];
		int         requests_noted;
		int         eos_noted;
		int         tokens_checked;
		int         dispatches;
		int         errors;

		function new();
			phase = PH_START;
			name_pos = 3'd0;
			type_possible = 0;
			data_possible = 0;
			after_cr = 0;
			pending = 0;
			data_seen = 0;
			requests_noted = 0;
			eos_noted = 0;
			tokens_checked = 0;
			dispatches = 0;
			errors = 0;
		endfunction

		function void queue_token(tok_kind_t k, logic [7:0] b);
			tok_t t;
			t.kind = k;
			t.data = b;
			t.last = 1'b0;
			item_toks.insert(item_toks.size(), t);
		endfunction

		// narrow the name candidates by one character
		function void match_name_char(logic [7:0] b);
			if (!(name_pos < 3'd5 && b == type_name[name_pos])) type_possible = 0;
			if (!(name_pos < 3'd4 && b == data_name[name_pos])) data_possible = 0;
			if (name_pos != 3'd7) name_pos = name_pos + 3'd1;
		endfunction

		// field name complete, at a colon or at the line end
		function void finish_name(bit colon);
			if (type_possible && name_pos == 3'd5) begin
				queue_token(TK_TYPE_BEGIN, 8'h00);
				pending = 1;
				if (colon) phase = PH_EV_FIRST;
				else phase = PH_SKIP;
			end else if (data_possible && name_pos == 3'd4) begin
				if (data_seen) queue_token(TK_DATA_BREAK, 8'h00);
				data_seen = 1;
				pending = 1;
				if (colon) phase = PH_DA_FIRST;
				else phase = PH_SKIP;
			end else begin
				phase = PH_SKIP;
			end
		endfunction

		function void flush_event();
			if (pending) queue_token(TK_DISPATCH, 8'h00);
			pending = 0;
			data_seen = 0;
		endfunction

		function void close_line();
			if (phase == PH_START) flush_event();
			else if (phase == PH_NAME) finish_name(0);
			phase = PH_START;
			name_pos = 3'd0;
			type_possible = 0;
			data_possible = 0;
		endfunction

		// accepted request: work out its tokens
		function void note_request(logic kind, logic [7:0] b);
			item_toks.delete();
			requests_noted++;
			if (kind == ITEM_EOS) begin
				eos_noted++;
				if (phase != PH_START) close_line();
				flush_event();
				after_cr = 0;
			end else if (after_cr && b == CH_LF) begin
				after_cr = 0;
			end else if (b == CH_LF || b == CH_CR) begin
				after_cr = (b == CH_CR);
				close_line();
			end else begin
				after_cr = 0;
				case (phase)
					PH_START: begin
						if (b == CH_COLON) begin
							phase = PH_SKIP;
						end else begin
							phase = PH_NAME;
							name_pos = 3'd0;
							type_possible = 1;
							data_possible = 1;
							match_name_char(b);
						end
					end
					PH_NAME: begin
						if (b == CH_COLON) finish_name(1);
						else match_name_char(b);
					end
					PH_EV_FIRST: begin
						phase = PH_EV;
						if (b != CH_SPACE) queue_token(TK_TYPE_BYTE, b);
					end
					PH_EV: queue_token(TK_TYPE_BYTE, b);
					PH_DA_FIRST: begin
						phase = PH_DA;
						if (b != CH_SPACE) queue_token(TK_DATA_BYTE, b);
					end
					PH_DA: queue_token(TK_DATA_BYTE, b);
					default: ;
				endcase
			end
			if (item_toks.size() > 0) item_toks[item_toks.size() - 1].last = 1'b1;
			for (int i = 0; i < item_toks.size(); i++)
				expected_q.insert(expected_q.size(), item_toks[i]);
		endfunction

		// accepted token: compare with the oldest expectation
		function void check_token(logic [2:0] kind, logic [7:0] b, logic last);
			tok_t want;
			tokens_checked++;
			if (expected_q.size() == 0) begin
				$error("token with nothing expected: token_kind %0d token_byte %02h", kind, b);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (want.kind == TK_DISPATCH) dispatches++;
			if (kind !== want.kind) begin
				$error("token_kind: expected %0d, actual %0d", want.kind, kind);
				errors++;
			end
			if (b !== want.data) begin
				$error("token_byte: expected %02h, actual %02h", want.data, b);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_item: expected %0b, actual %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	esp_item_if  item_ch();
	esp_token_if token_ch();

	event_stream_line_parser_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.token  (token_ch)
	);

	token_scoreboard sb;
	stream_req_t     stream_q[$];
	int              seg_left[2];
	bit              seg_quiet[2];
	int              stall_cycles;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle cycles for one side: quiet stretches alternate with busy ones
	function automatic int draw_wait(int side);
		if (seg_left[side] == 0) begin
			seg_left[side] = $urandom_range(10, 60);
			seg_quiet[side] = ($urandom_range(0, 2) == 0);
		end
		seg_left[side]--;
		if (seg_quiet[side]) return 0;
		return $urandom_range(0, 6);
	endfunction

	// stream building
	task automatic put_byte(logic [7:0] b);
		stream_req_t r;
		r.kind = ITEM_BYTE;
		r.value = b;
		stream_q.insert(stream_q.size(), r);
	endtask

	task automatic put_eos();
		stream_req_t r;
		r.kind = ITEM_EOS;
		r.value = 8'($urandom_range(0, 255));
		stream_q.insert(stream_q.size(), r);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	function automatic logic [7:0] name_char();
		string      pool;
		logic [7:0] c;
		pool = "evntda";
		if ($urandom_range(0, 3) != 0) return pool[$urandom_range(0, 5)];
		do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR || c == CH_COLON);
		return c;
	endfunction

	function automatic logic [7:0] content_byte();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: c = CH_SPACE;
			1: c = CH_COLON;
			default: do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
		endcase
		return c;
	endfunction

	task automatic put_value();
		if ($urandom_range(0, 1) == 1) put_byte(CH_SPACE);
		repeat ($urandom_range(0, 8)) put_byte(content_byte());
	endtask

	task automatic put_line_end();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: put_byte(CH_LF);
			4, 5: put_byte(CH_CR);
			6, 7, 8: begin
				put_byte(CH_CR);
				put_byte(CH_LF);
			end
			default: begin
				if ($urandom_range(0, 1) == 1) put_byte(CH_CR);
				put_eos();
			end
		endcase
	endtask

	// one random line: mostly well-formed fields, some noise
	task automatic add_random_line();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 9) == 0) put_eos();
				else put_byte(8'($urandom_range(0, 255)));
			end
			return;
		end
		if (pick < 20) begin
			put_line_end();
			return;
		end
		if (pick < 27) begin
			put_byte(CH_COLON);
			put_value();
			put_line_end();
			return;
		end
		if (pick < 55) put_text("data");
		else if (pick < 80) put_text("event");
		else repeat ($urandom_range(1, 9)) put_byte(name_char());
		if ($urandom_range(0, 7) != 0) begin
			put_byte(CH_COLON);
			put_value();
		end
		put_line_end();
	endtask

	// request driver
	task automatic send_request(stream_req_t r);
		int gap;
		gap = draw_wait(SIDE_ITEM);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.item_kind <= r.kind;
		item_ch.byte_value <= r.value;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	// token sink with random back-pressure
	initial begin
		int gap;
		token_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_wait(SIDE_TOKEN);
			if (gap > 0) begin
				token_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			token_ch.ready <= 1'b1;
			@(posedge clk);
			while (!token_ch.valid) @(posedge clk);
		end
	end

	// handshake monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				sb.note_request(item_ch.item_kind, item_ch.byte_value);
			if (token_ch.valid && token_ch.ready)
				sb.check_token(token_ch.token_kind, token_ch.token_byte,
					token_ch.last_of_item);
		end
	end

	// watchdog on cycles with no request and no token accepted
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (token_ch.valid && token_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$error("no handshake for %0d cycles, %0d tokens still expected",
			WATCHDOG_LIMIT, sb.expected_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// main sequence
	initial begin
		int directed_count;
		clk = 1'b0;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.item_kind <= ITEM_BYTE;
		item_ch.byte_value <= 8'h00;
		seg_left[SIDE_ITEM] = 0;
		seg_left[SIDE_TOKEN] = 0;
		sb = new();

		// event line with the space dropped, a zero type byte, crlf end
		put_text("event: ");
		put_byte(8'h00);
		put_byte(CH_CR);
		put_byte(CH_LF);
		// first data line with an all-ones byte, cr end
		put_text("data:");
		put_byte(8'hff);
		put_byte(CH_CR);
		// data name with no colon cut off by end of stream: break, then dispatch
		put_text("data");
		put_eos();
		// comment line, trailing cr right before end of stream, nothing pending
		put_byte(CH_COLON);
		put_byte(CH_CR);
		put_eos();
		// blank line with nothing pending
		put_byte(CH_LF);
		directed_count = stream_q.size();

		while (stream_q.size() - directed_count < RANDOM_REQUESTS) add_random_line();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stream_q[i]) send_request(stream_q[i]);
		item_ch.valid <= 1'b0;

		while (!(sb.requests_noted == stream_q.size() && sb.expected_q.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d end of stream), %0d tokens checked, %0d dispatches",
			sb.requests_noted, sb.eos_noted, sb.tokens_checked, sb.dispatches);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
